// ===== sv/pwmm_pkg.sv =====
// shared types and constants for the pot-to-pwm setting mapper
// no dependencies; imported by every module of the block
package pwmm_pkg;

    localparam int unsigned SAMPLE_WIDTH_DEF = 10;
    localparam int unsigned CH_COUNT         = 3;

    localparam logic [1:0] FD_SHIFT_RST    = 2'd2;
    localparam logic [1:0] PRESC_SHIFT_RST = 2'd3;
    localparam logic       TOP_NZ_RST      = 1'b1;
    localparam logic       PRESC_FOL_RST   = 1'b1;
    localparam logic [3:0] CS_RST          = 4'd1;
    localparam logic [7:0] TOP_MAX         = 8'd255;

    typedef enum logic [1:0] {
        CH_FREQ   = 2'd0,
        CH_DUTY   = 2'd1,
        CH_PRESC  = 2'd2,
        CH_UNUSED = 2'd3
    } chan_t;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_FULL = 2'd1,
        MODE_RUN  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_FD_SHIFT    = 2'd0,
        REG_PRESC_SHIFT = 2'd1,
        REG_TOP_NZ      = 2'd2,
        REG_PRESC_FOL   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] fd_shift;
        logic [1:0] presc_shift;
        logic       top_nz;
        logic       presc_follow;
    } cfg_t;

    // floor(x / (2^w - 1)) by folding the high part back in twice
    function automatic logic [31:0] div_full(input logic [31:0] x, input int unsigned w);
        logic [31:0] m;
        logic [31:0] t;
        logic [31:0] r1;
        logic [31:0] t2;
        logic [31:0] r2;
        m  = (32'd1 << w) - 32'd1;
        t  = x >> w;
        r1 = (x & m) + t;
        t2 = r1 >> w;
        r2 = (r1 & m) + t2;
        return t + t2 + ((r2 >= m) ? 32'd1 : 32'd0);
    endfunction

endpackage

// ===== sv/pot_to_pwm_setting_mapper.sv =====
// top level of the pot-to-pwm setting mapper: config registers and pipeline
// depends on pwmm_pkg, pwmm_accum, pwmm_scale, pwmm_out
//
// Converter samples enter on the s_ stream, sample in s_tdata and the source
// pot in s_tuser (0 frequency, 1 duty, 2 prescaler, 3 ignored). Each channel
// is averaged over 2^shift samples. A finished frequency average updates the
// held top value, a finished prescaler average (if presc_follow) the held
// clock select; only a finished duty average emits a word on the m_ stream.
// The cfg_ port writes the four settings and is always ready.
// A duty word passes the input register, loaded at the edge that accepts the
// sample completing its average, then the sum, product and result registers.
// Throughput: one sample per cycle, set by the single-pass stages, as long as
// a receiver stall has not backed up to the input.
// Reset clears sums, counts, the top value (to 0) and sets the clock select
// to 1 and the settings to their defaults.
// When the receiver stalls, the result register holds its word; stages
// behind it keep filling bubbles and s_tready drops only once every stage
// holds a word.
module pot_to_pwm_setting_mapper #(
    parameter int unsigned SAMPLE_WIDTH = pwmm_pkg::SAMPLE_WIDTH_DEF,
    parameter int unsigned S_TDATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // sample
    input  logic [1:0]           s_tuser,   // channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // top_value, compare_value, drive_mode, clock_select, main_pin_level,
    // anti_pin_level
    output logic [23:0]          m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [1:0]           cfg_data
);
    import pwmm_pkg::*;

    cfg_t                     cfg_reg;
    logic                     avg_valid;
    logic                     avg_ready;
    logic [1:0]               avg_chan;
    logic [SAMPLE_WIDTH+2:0]  avg_data;
    logic                     prod_valid;
    logic                     prod_ready;
    logic [SAMPLE_WIDTH+10:0] prod_data;
    logic [7:0]               prod_top;
    logic [3:0]               prod_cs;
    logic [7:0]               m_top;
    logic [7:0]               m_cmp;
    logic [1:0]               m_mode;
    logic [3:0]               m_cs;
    logic                     m_main;
    logic                     m_anti;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fd_shift     <= FD_SHIFT_RST;
            cfg_reg.presc_shift  <= PRESC_SHIFT_RST;
            cfg_reg.top_nz       <= TOP_NZ_RST;
            cfg_reg.presc_follow <= PRESC_FOL_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
                REG_FD_SHIFT:    cfg_reg.fd_shift     <= cfg_data;
                REG_PRESC_SHIFT: cfg_reg.presc_shift  <= cfg_data;
                REG_TOP_NZ:      cfg_reg.top_nz       <= cfg_data[0];
                REG_PRESC_FOL:   cfg_reg.presc_follow <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    pwmm_accum #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_sample  (s_tdata[SAMPLE_WIDTH-1:0]),
        .s_chan    (s_tuser),
        .avg_valid (avg_valid),
        .avg_ready (avg_ready),
        .avg_chan  (avg_chan),
        .avg_data  (avg_data)
    );

    pwmm_scale #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .avg_valid  (avg_valid),
        .avg_ready  (avg_ready),
        .avg_chan   (avg_chan),
        .avg_data   (avg_data),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod_data  (prod_data),
        .prod_top   (prod_top),
        .prod_cs    (prod_cs)
    );

    pwmm_out #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod_data  (prod_data),
        .prod_top   (prod_top),
        .prod_cs    (prod_cs),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_top      (m_top),
        .m_cmp      (m_cmp),
        .m_mode     (m_mode),
        .m_cs       (m_cs),
        .m_main     (m_main),
        .m_anti     (m_anti)
    );

    assign m_tdata = {m_anti, m_main, m_cs, m_mode, m_cmp, m_top};

    a_hold_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed or dropped while stalled");

    a_full_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_mode == MODE_FULL) |-> (m_cmp == TOP_MAX && m_main && !m_anti))
        else $error("full-on word without maximum compare or with wrong pins");

    a_off_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_mode == MODE_OFF) |-> (!m_main && m_anti))
        else $error("off word with wrong pins");

endmodule

// ===== sv/pwmm_accum.sv =====
// input register and per-channel running sums with power-of-two averaging
// depends on pwmm_pkg
module pwmm_accum #(
    parameter int unsigned SAMPLE_WIDTH = pwmm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pwmm_pkg::cfg_t          cfg,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [SAMPLE_WIDTH-1:0] s_sample,
    input  logic [1:0]              s_chan,
    output logic                    avg_valid,
    input  logic                    avg_ready,
    output logic [1:0]              avg_chan,
    output logic [SAMPLE_WIDTH+2:0] avg_data
);
    import pwmm_pkg::*;

    localparam int unsigned SUM_W = SAMPLE_WIDTH + 3;

    logic                    in_valid_reg;
    logic [SAMPLE_WIDTH-1:0] in_sample_reg;
    logic [1:0]              in_chan_reg;
    logic                    avg_valid_reg;
    logic [1:0]              avg_chan_reg;
    logic [SUM_W-1:0]        avg_data_reg;
    logic [SUM_W-1:0]        sum_reg [CH_COUNT];
    logic [3:0]              cnt_reg [CH_COUNT];

    logic                    adv;
    logic                    commit;
    logic                    used;
    logic [1:0]              sel;
    logic [1:0]              shift;
    logic [SUM_W-1:0]        sum_next;
    logic [3:0]              cnt_next;
    logic                    done;
    logic [SUM_W-1:0]        avg_next;

    assign adv     = !avg_valid_reg || avg_ready;
    assign s_ready = !in_valid_reg || adv;
    assign commit  = in_valid_reg && adv;
    assign used    = in_chan_reg != CH_UNUSED;
    assign sel     = used ? in_chan_reg : CH_FREQ;
    assign shift   = (in_chan_reg == CH_PRESC) ? cfg.presc_shift : cfg.fd_shift;
    assign sum_next = sum_reg[sel] + SUM_W'(in_sample_reg);
    assign cnt_next = cnt_reg[sel] + 4'd1;
    assign done     = cnt_next >= (4'd1 << shift);
    assign avg_next = sum_next >> shift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            avg_valid_reg <= 1'b0;
            for (int i = 0; i < CH_COUNT; i++) begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv) begin
                avg_valid_reg <= commit && used && done;
            end
            if (commit && used) begin
                sum_reg[sel] <= done ? '0 : sum_next;
                cnt_reg[sel] <= done ? '0 : cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
            in_chan_reg   <= s_chan;
        end
        if (adv) begin
            avg_data_reg <= avg_next;
            avg_chan_reg <= in_chan_reg;
        end
    end

    assign avg_valid = avg_valid_reg;
    assign avg_chan  = avg_chan_reg;
    assign avg_data  = avg_data_reg;

endmodule

// ===== sv/pwmm_scale.sv =====
// held top value and clock select, and the duty product average * top
// depends on pwmm_pkg
module pwmm_scale #(
    parameter int unsigned SAMPLE_WIDTH = pwmm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pwmm_pkg::cfg_t           cfg,
    input  logic                     avg_valid,
    output logic                     avg_ready,
    input  logic [1:0]               avg_chan,
    input  logic [SAMPLE_WIDTH+2:0]  avg_data,
    output logic                     prod_valid,
    input  logic                     prod_ready,
    output logic [SAMPLE_WIDTH+10:0] prod_data,
    output logic [7:0]               prod_top,
    output logic [3:0]               prod_cs
);
    import pwmm_pkg::*;

    localparam int unsigned AW = SAMPLE_WIDTH + 3;
    localparam int unsigned PW = AW + 8;
    localparam int unsigned CW = AW + 4;

    logic [7:0]    top_val_reg;
    logic [3:0]    cs_reg;
    logic          prod_valid_reg;
    logic [PW-1:0] prod_data_reg;
    logic [7:0]    prod_top_reg;
    logic [3:0]    prod_cs_reg;

    logic          adv;
    logic          commit;
    logic [PW-1:0] x255;
    logic [CW-1:0] x15;
    logic [10:0]   q255;
    logic [6:0]    q15;
    logic [7:0]    top_next;
    logic [3:0]    cs_next;
    logic [PW-1:0] prod_next;

    assign adv       = !prod_valid_reg || prod_ready;
    assign avg_ready = adv;
    assign commit    = avg_valid && adv;

    // avg * 255 and avg * 15 by shift and subtract
    assign x255 = {avg_data, 8'd0} - PW'(avg_data);
    assign x15  = {avg_data, 4'd0} - CW'(avg_data);
    assign q255 = 11'(div_full(32'(x255), SAMPLE_WIDTH));
    assign q15  = 7'(div_full(32'(x15), SAMPLE_WIDTH));

    // top wraps to 8 bits; only an exact zero before wrapping is raised, if top_nz
    always_comb begin
        top_next = TOP_MAX - q255[7:0];
        if (q255 == 11'(TOP_MAX) && cfg.top_nz) begin
            top_next = 8'd1;
        end
        cs_next = (q15 == 7'd0) ? 4'd1 : q15[3:0];
    end

    assign prod_next = PW'(avg_data) * PW'(top_val_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_val_reg    <= 8'd0;
            cs_reg         <= CS_RST;
            prod_valid_reg <= 1'b0;
        end else begin
            if (commit && avg_chan == CH_FREQ) begin
                top_val_reg <= top_next;
            end
            if (commit && avg_chan == CH_PRESC && cfg.presc_follow) begin
                cs_reg <= cs_next;
            end
            if (adv) begin
                prod_valid_reg <= commit && avg_chan == CH_DUTY;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_data_reg <= prod_next;
            prod_top_reg  <= top_val_reg;
            prod_cs_reg   <= cs_reg;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod_data  = prod_data_reg;
    assign prod_top   = prod_top_reg;
    assign prod_cs    = prod_cs_reg;

endmodule

// ===== sv/pwmm_out.sv =====
// compare value, drive mode and pin levels, held in the result register
// depends on pwmm_pkg
module pwmm_out #(
    parameter int unsigned SAMPLE_WIDTH = pwmm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     prod_valid,
    output logic                     prod_ready,
    input  logic [SAMPLE_WIDTH+10:0] prod_data,
    input  logic [7:0]               prod_top,
    input  logic [3:0]               prod_cs,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_top,
    output logic [7:0]               m_cmp,
    output logic [1:0]               m_mode,
    output logic [3:0]               m_cs,
    output logic                     m_main,
    output logic                     m_anti
);
    import pwmm_pkg::*;

    logic       out_valid_reg;
    logic [7:0] top_reg;
    logic [7:0] cmp_reg;
    mode_t      mode_reg;
    logic [3:0] cs_reg;
    logic       main_reg;
    logic       anti_reg;

    logic       adv;
    logic [7:0] cmp_next;
    mode_t      mode_next;
    logic       main_next;
    logic       anti_next;

    assign adv        = !out_valid_reg || m_ready;
    assign prod_ready = adv;
    assign cmp_next   = 8'(div_full(32'(prod_data), SAMPLE_WIDTH));

    always_comb begin
        if (prod_top == 8'd0 || cmp_next == 8'd0) begin
            mode_next = MODE_OFF;
        end else if (cmp_next == TOP_MAX) begin
            mode_next = MODE_FULL;
        end else begin
            mode_next = MODE_RUN;
        end
    end

    always_comb begin
        case (mode_next)
            MODE_OFF: begin
                main_next = 1'b0;
                anti_next = 1'b1;
            end
            MODE_FULL: begin
                main_next = 1'b1;
                anti_next = 1'b0;
            end
            default: begin
                main_next = 1'b0;
                anti_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= prod_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && prod_valid) begin
            top_reg  <= prod_top;
            cmp_reg  <= cmp_next;
            mode_reg <= mode_next;
            cs_reg   <= prod_cs;
            main_reg <= main_next;
            anti_reg <= anti_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_top   = top_reg;
    assign m_cmp   = cmp_reg;
    assign m_mode  = mode_reg;
    assign m_cs    = cs_reg;
    assign m_main  = main_reg;
    assign m_anti  = anti_reg;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// stream testbench for pot_to_pwm_setting_mapper: directed table then random phases
// depends on pwmm_pkg and the pot_to_pwm_setting_mapper rtl
module tb;
    import pwmm_pkg::*;

    localparam int unsigned FULL_SCALE = 1023;
    localparam int          LATENCY    = 4;
    localparam int          PHASES     = 12;
    localparam int          PHASE_LEN  = 100;
    localparam int          HOLD_LEN   = 300;
    localparam int          PLAN_LEN   = 26;

    typedef struct packed {
        logic       anti_lvl;
        logic       main_lvl;
        logic [3:0] clk_sel;
        mode_t      mode;
        logic [7:0] cmp;
        logic [7:0] top;
    } pwm_word_t;

    typedef struct {
        bit         is_set;
        logic [1:0] code;
        logic [9:0] value;
        bit         typed;
        pwm_word_t  word;
    } plan_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;    // sample
    logic [1:0]  s_tuser   = '0;    // channel
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // top_value, compare_value, drive_mode, clock_select, main_pin_level,
    // anti_pin_level
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [1:0]  cfg_data  = '0;

    pot_to_pwm_setting_mapper uut (.*);

    pwm_word_t   due_words [$];
    int          fails     = 0;
    bit          quiet     = 0;
    bit          hold_req  = 0;

    int unsigned sum_q [3] = '{0, 0, 0};
    int unsigned cnt_q [3] = '{0, 0, 0};
    logic [7:0]  top_q     = '0;
    logic [3:0]  cs_q      = CS_RST;
    logic [1:0]  fd_sh     = FD_SHIFT_RST;
    logic [1:0]  ps_sh     = PRESC_SHIFT_RST;
    logic        tnz       = TOP_NZ_RST;
    logic        pfol      = PRESC_FOL_RST;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit average_done(input chan_t ch, input logic [9:0] smp,
                                        input logic [1:0] sh, output int unsigned avg);
        sum_q[ch] += smp;
        cnt_q[ch] += 1;
        avg = 0;
        if (cnt_q[ch] >= (32'd1 << sh)) begin
            avg = sum_q[ch] >> sh;
            sum_q[ch] = 0;
            cnt_q[ch] = 0;
            return 1;
        end
        return 0;
    endfunction

    function automatic bit map_sample(input chan_t ch, input logic [9:0] smp,
                                      output pwm_word_t w);
        int unsigned avg;
        int unsigned v;
        w = '0;
        case (ch)
            CH_FREQ: begin
                if (average_done(ch, smp, fd_sh, avg)) begin
                    v = 255 - (avg * 255) / FULL_SCALE;
                    if (v == 0 && tnz) v = 1;
                    top_q = v[7:0];
                end
            end
            CH_PRESC: begin
                if (average_done(ch, smp, ps_sh, avg) && pfol) begin
                    v = (avg * 15) / FULL_SCALE;
                    if (v < 1) v = 1;
                    cs_q = v[3:0];
                end
            end
            CH_DUTY: begin
                if (average_done(ch, smp, fd_sh, avg)) begin
                    v = ((avg * top_q) / FULL_SCALE) & 32'hFF;
                    w.top = top_q;
                    w.cmp = v[7:0];
                    w.clk_sel = cs_q;
                    if (top_q == 0 || v == 0) begin
                        w.mode = MODE_OFF;
                        w.anti_lvl = 1'b1;
                    end else if (v >= 255) begin
                        w.mode = MODE_FULL;
                        w.main_lvl = 1'b1;
                    end else begin
                        w.mode = MODE_RUN;
                    end
                    return 1;
                end
            end
            default: ;
        endcase
        return 0;
    endfunction

    function automatic void apply_setting(input reg_idx_t idx, input logic [1:0] val);
        case (idx)
            REG_FD_SHIFT:    fd_sh = val;
            REG_PRESC_SHIFT: ps_sh = val;
            REG_TOP_NZ:      tnz   = val[0];
            REG_PRESC_FOL:   pfol  = val[0];
            default: ;
        endcase
    endfunction

    function automatic pwm_word_t mk_word(input logic [7:0] top, input logic [7:0] cmp,
                                          input mode_t mode, input logic [3:0] cs,
                                          input logic main_lvl, input logic anti_lvl);
        pwm_word_t w;
        w.top = top;
        w.cmp = cmp;
        w.mode = mode;
        w.clk_sel = cs;
        w.main_lvl = main_lvl;
        w.anti_lvl = anti_lvl;
        return w;
    endfunction

    function automatic logic [9:0] draw_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 10'($urandom_range(0, 6));
        if (r == 2) return 10'($urandom_range(1017, 1023));
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic void field_check(input string name, input int unsigned exp_v,
                                        input int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, got_v);
            fails++;
        end
    endfunction

    // all tasks below start and end at a falling edge
    task automatic write_setting(input reg_idx_t idx, input logic [1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_setting(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (due_words.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic feed(input chan_t ch, input logic [9:0] smp,
                        output bit made, output pwm_word_t w);
        while (!quiet && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= {6'b0, smp};
        do @(posedge aclk); while (!s_tready);
        made = map_sample(ch, smp, w);
        @(negedge aclk);
    endtask

    // receiver with random stalls and one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= quiet || ($urandom_range(0, 99) >= 28);
            end
        end
    end

    always @(posedge aclk) begin : check_words
        pwm_word_t got;
        pwm_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (due_words.size() == 0) begin
                $display("%0t unexpected word: expected none actual %h", $time, m_tdata);
                fails++;
            end else begin
                exp_w = due_words.pop_front();
                field_check("top_value", exp_w.top, got.top);
                field_check("compare_value", exp_w.cmp, got.cmp);
                field_check("drive_mode", exp_w.mode, got.mode);
                field_check("clock_select", exp_w.clk_sel, got.clk_sel);
                field_check("main_pin_level", exp_w.main_lvl, got.main_lvl);
                field_check("anti_pin_level", exp_w.anti_lvl, got.anti_lvl);
            end
        end
    end

    initial begin : stimulus
        plan_row_t  plan [PLAN_LEN];
        pwm_word_t  w;
        bit         made;
        chan_t      ch;
        logic [9:0] smp;
        logic [9:0] steady_val [3];
        bit         steady;
        int         fed;
        int         r;

        plan = '{
            '{1'b1, REG_FD_SHIFT,    10'd0,    1'b0, '0},
            '{1'b1, REG_PRESC_SHIFT, 10'd0,    1'b0, '0},
            '{1'b0, CH_DUTY,   10'd1023, 1'b1,
              mk_word(8'd0, 8'd0, MODE_OFF, 4'd1, 1'b0, 1'b1)},
            '{1'b0, CH_FREQ,   10'd1023, 1'b0, '0},
            '{1'b0, CH_DUTY,   10'd1023, 1'b1,
              mk_word(8'd1, 8'd1, MODE_RUN, 4'd1, 1'b0, 1'b0)},
            '{1'b1, REG_TOP_NZ,      10'd0,    1'b0, '0},
            '{1'b0, CH_FREQ,   10'd1023, 1'b0, '0},
            '{1'b0, CH_DUTY,   10'd1023, 1'b1,
              mk_word(8'd0, 8'd0, MODE_OFF, 4'd1, 1'b0, 1'b1)},
            '{1'b0, CH_FREQ,   10'd0,    1'b0, '0},
            '{1'b0, CH_DUTY,   10'd1023, 1'b1,
              mk_word(8'd255, 8'd255, MODE_FULL, 4'd1, 1'b1, 1'b0)},
            '{1'b0, CH_DUTY,   10'd0,    1'b1,
              mk_word(8'd255, 8'd0, MODE_OFF, 4'd1, 1'b0, 1'b1)},
            '{1'b0, CH_PRESC,  10'd1023, 1'b0, '0},
            '{1'b0, CH_DUTY,   10'd512,  1'b0, '0},
            '{1'b1, REG_PRESC_FOL,   10'd0,    1'b0, '0},
            '{1'b0, CH_PRESC,  10'd0,    1'b0, '0},
            '{1'b0, CH_DUTY,   10'd512,  1'b0, '0},
            '{1'b1, REG_PRESC_FOL,   10'd1,    1'b0, '0},
            '{1'b0, CH_PRESC,  10'd0,    1'b0, '0},
            '{1'b0, CH_UNUSED, 10'd1023, 1'b0, '0},
            '{1'b0, CH_DUTY,   10'd1,    1'b0, '0},
            '{1'b1, REG_FD_SHIFT,    10'd3,    1'b0, '0},
            '{1'b0, CH_DUTY,   10'h2AA,  1'b0, '0},
            '{1'b0, CH_DUTY,   10'h155,  1'b0, '0},
            // shift lowered with a partial average pending
            '{1'b1, REG_FD_SHIFT,    10'd1,    1'b0, '0},
            '{1'b0, CH_DUTY,   10'd1023, 1'b0, '0},
            '{1'b1, REG_TOP_NZ,      10'd1,    1'b0, '0}
        };

        aresetn <= 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_set) begin
                settle();
                write_setting(reg_idx_t'(plan[i].code), plan[i].value[1:0]);
            end else begin
                feed(chan_t'(plan[i].code), plan[i].value, made, w);
                if (made) due_words.push_back(plan[i].typed ? plan[i].word : w);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph == 0) begin
                write_setting(REG_FD_SHIFT, 2'd3);
                write_setting(REG_PRESC_SHIFT, 2'd3);
                write_setting(REG_TOP_NZ, 2'd1);
                write_setting(REG_PRESC_FOL, 2'd1);
            end else if (ph == 1) begin
                write_setting(REG_FD_SHIFT, 2'd0);
                write_setting(REG_PRESC_SHIFT, 2'd0);
                write_setting(REG_TOP_NZ, 2'd0);
                write_setting(REG_PRESC_FOL, 2'd0);
            end else begin
                write_setting(REG_FD_SHIFT, 2'($urandom_range(0, 3)));
                write_setting(REG_PRESC_SHIFT, 2'($urandom_range(0, 3)));
                write_setting(REG_TOP_NZ, 2'($urandom_range(0, 3)));
                write_setting(REG_PRESC_FOL, 2'($urandom_range(0, 3)));
            end
            quiet = (ph == 2);
            // steady phases model a pot left in place with occasional jitter
            steady = (ph % 2 == 0);
            for (int c = 0; c < 3; c++) begin
                r = $urandom_range(0, 3);
                steady_val[c] = (r == 0) ? 10'd0 : (r == 1) ? 10'd1023 : draw_sample();
            end
            fed = 0;
            while (fed < PHASE_LEN) begin
                r = $urandom_range(0, 19);
                ch = (r < 8) ? CH_DUTY : (r < 13) ? CH_FREQ : (r < 18) ? CH_PRESC : CH_UNUSED;
                if (steady && ch != CH_UNUSED && $urandom_range(0, 4) != 0)
                    smp = steady_val[ch];
                else
                    smp = draw_sample();
                if (ph == 4 && fed == 10) hold_req = 1;
                if (ph == 6 && fed == 50) begin
                    s_tvalid <= 1'b0;
                    while (due_words.size() != 0) @(negedge aclk);
                end
                feed(ch, smp, made, w);
                if (made) due_words.push_back(w);
                fed++;
            end
        end
        quiet = 0;

        s_tvalid <= 1'b0;
        while (due_words.size() != 0) @(negedge aclk);
        repeat (LATENCY * 4) @(posedge aclk);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== pot_to_pwm_setting_mapper.f =====
sv/pwmm_pkg.sv
sv/pwmm_accum.sv
sv/pwmm_scale.sv
sv/pwmm_out.sv
sv/pot_to_pwm_setting_mapper.sv
verif/tb.sv
